/* sv/psbc_pkg.sv */
// ----------------------------------------------------------------------------
// psbc_pkg
// Shared constants, register indexes, control struct and saturation helpers
// for the particle step and box collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package psbc_pkg;

  localparam int FRAC_BITS   = 16;  // Q16.16 values
  localparam int FACTOR_BITS = 16;  // Q1.16 factors
  localparam int VAL_W       = 32;
  localparam int AGE_W       = 31;
  localparam int FACT_W      = 17;
  localparam int PROD_W      = 49;  // value times factor, signed
  localparam int DTP_W       = 63;  // value times dt, signed

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;

  localparam logic [FACT_W-1:0] FACTOR_ONE = 17'd65536;

  // per-particle side information carried down the pipe
  typedef struct packed {
    logic [VAL_W-1:0] pos_x;       // clamped position, signed
    logic [VAL_W-1:0] pos_y;
    logic             hit_edge_x;
    logic             hit_zero_x;
    logic             hit_edge_y;
    logic             hit_zero_y;
    logic             alive;
    logic [AGE_W-1:0] dt;
    logic [AGE_W-1:0] new_age;
    logic [AGE_W-1:0] life;
  } ctl_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // value times Q1.16 factor, floor shift, saturate
  function automatic logic signed [VAL_W-1:0] sat_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [63:0] w;
    w = 64'(p) >>> FACTOR_BITS;
    return sat32(w);
  endfunction

endpackage

`default_nettype wire

/* sv/psbc_front.sv */
// ----------------------------------------------------------------------------
// psbc_front
// Stages 1 to 3: box test and clamp, age check, gravity, drag products.
// ----------------------------------------------------------------------------
`default_nettype none

module psbc_front (
  input  wire logic                                       clk,
  input  wire logic                                       en,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          pos_x,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          pos_y,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          vel_x,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          vel_y,
  input  wire logic        [psbc_pkg::AGE_W-1:0]          age,
  input  wire logic        [psbc_pkg::AGE_W-1:0]          lifetime,
  input  wire logic        [psbc_pkg::AGE_W-1:0]          step_time,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          gravity_accel,
  input  wire logic        [psbc_pkg::FACT_W-1:0]         drag_factor,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          box_origin_x,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]          box_origin_y,
  input  wire logic        [psbc_pkg::AGE_W-1:0]          box_length,
  input  wire logic        [psbc_pkg::AGE_W-1:0]          box_height,
  output logic signed      [psbc_pkg::PROD_W-1:0]         prod_x,
  output logic signed      [psbc_pkg::PROD_W-1:0]         prod_y,
  output psbc_pkg::ctl_t                                  ctl
);

  // stage 1 logic
  logic signed [psbc_pkg::VAL_W-1:0] edge_x, edge_y, clip_x, clip_y;
  logic                              over_x, over_y;
  logic        [psbc_pkg::AGE_W:0]   age_sum;
  logic signed [63:0]                g_full;
  psbc_pkg::ctl_t                    ctl_s1;

  // stage registers
  logic signed [psbc_pkg::DTP_W-1:0] g_dt;
  logic signed [psbc_pkg::VAL_W-1:0] vx1, vy1, vx2, vy2;
  psbc_pkg::ctl_t                    ctl1, ctl2;

  // stage 2/3 logic
  logic signed [psbc_pkg::VAL_W-1:0] vy_g;
  logic signed [49:0]                full_x, full_y;

  always_comb begin
    edge_x = psbc_pkg::sat32(64'(box_origin_x) + $signed({33'd0, box_length}));
    edge_y = psbc_pkg::sat32(64'(box_origin_y) + $signed({33'd0, box_height}));
    over_x = pos_x > edge_x;
    over_y = pos_y > edge_y;
    clip_x = over_x ? edge_x : pos_x;
    clip_y = over_y ? edge_y : pos_y;
    age_sum = {1'b0, age} + {1'b0, step_time};

    ctl_s1.hit_edge_x = over_x;
    ctl_s1.hit_edge_y = over_y;
    ctl_s1.hit_zero_x = clip_x[psbc_pkg::VAL_W-1];
    ctl_s1.hit_zero_y = clip_y[psbc_pkg::VAL_W-1];
    ctl_s1.pos_x      = clip_x[psbc_pkg::VAL_W-1] ? '0 : clip_x;
    ctl_s1.pos_y      = clip_y[psbc_pkg::VAL_W-1] ? '0 : clip_y;
    ctl_s1.alive      = age < lifetime;
    ctl_s1.dt         = step_time;
    ctl_s1.new_age    = age_sum[psbc_pkg::AGE_W] ? '1 : age_sum[psbc_pkg::AGE_W-1:0];
    ctl_s1.life       = lifetime;

    g_full = gravity_accel * $signed({1'b0, step_time});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_dt <= g_full[psbc_pkg::DTP_W-1:0];
      vx1  <= vel_x;
      vy1  <= vel_y;
      ctl1 <= ctl_s1;
    end
  end

  // gravity: vy += g*dt
  assign vy_g = psbc_pkg::sat32((64'(g_dt) >>> psbc_pkg::FRAC_BITS) + 64'(vy1));

  always_ff @(posedge clk) begin
    if (en) begin
      vx2  <= vx1;
      vy2  <= vy_g;
      ctl2 <= ctl1;
    end
  end

  // drag products
  assign full_x = vx2 * $signed({1'b0, drag_factor});
  assign full_y = vy2 * $signed({1'b0, drag_factor});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= full_x[psbc_pkg::PROD_W-1:0];
      prod_y <= full_y[psbc_pkg::PROD_W-1:0];
      ctl    <= ctl2;
    end
  end

endmodule

`default_nettype wire

/* sv/psbc_bounce.sv */
// ----------------------------------------------------------------------------
// psbc_bounce
// One wall stage for one axis: resolve the pending product (or pass the
// previous value on when take is low), then form the damped reflection product of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module psbc_bounce (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic                               take,
  input  wire logic signed [psbc_pkg::PROD_W-1:0] prod_in,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]  prev_in,
  input  wire logic        [psbc_pkg::FACT_W-1:0] damping,
  output logic signed      [psbc_pkg::VAL_W-1:0]  val_out,
  output logic signed      [psbc_pkg::PROD_W-1:0] prod_out
);

  logic signed [psbc_pkg::VAL_W-1:0] val;
  logic signed [psbc_pkg::VAL_W:0]   neg;
  logic signed [50:0]                full;

  assign val  = take ? psbc_pkg::sat_prod(prod_in) : prev_in;
  assign neg  = -(33'(val));  // exact, -(-2^31) fits
  assign full = neg * $signed({1'b0, damping});

  always_ff @(posedge clk) begin
    if (en) begin
      val_out  <= val;
      prod_out <= full[psbc_pkg::PROD_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/psbc_move.sv */
// ----------------------------------------------------------------------------
// psbc_move
// Last two stages for one axis: final velocity, v*dt product, then the
// saturated position update.
// ----------------------------------------------------------------------------
`default_nettype none

module psbc_move (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic                               take,
  input  wire logic signed [psbc_pkg::PROD_W-1:0] prod_in,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]  prev_in,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]  pos_in,
  input  wire logic        [psbc_pkg::AGE_W-1:0]  dt,
  output logic signed      [psbc_pkg::VAL_W-1:0]  new_pos,
  output logic signed      [psbc_pkg::VAL_W-1:0]  new_vel
);

  logic signed [psbc_pkg::VAL_W-1:0] val, val_a, pos_a;
  logic signed [63:0]                full;
  logic signed [psbc_pkg::DTP_W-1:0] vdt;

  assign val  = take ? psbc_pkg::sat_prod(prod_in) : prev_in;
  assign full = val * $signed({1'b0, dt});

  always_ff @(posedge clk) begin
    if (en) begin
      val_a <= val;
      pos_a <= pos_in;
      vdt   <= full[psbc_pkg::DTP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_vel <= val_a;
      new_pos <= psbc_pkg::sat32((64'(vdt) >>> psbc_pkg::FRAC_BITS) + 64'(pos_a));
    end
  end

endmodule

`default_nettype wire

/* sv/particle_step_box_collide.sv */
// ----------------------------------------------------------------------------
// particle_step_box_collide
// One-frame Euler update of a particle with box wall reflection and
// lifetime removal, as a seven-stage pipeline.
// ----------------------------------------------------------------------------
// Accepts one particle per clock unless the output stalls, returning it on the
// output channel; a particle whose age has reached its lifetime is dropped
// at the last stage and produces no output transaction. Throughput is one
// transaction per cycle: all seven register stages advance together whenever
// the output register can move, and each stage holds at most one multiplier
// per axis: gravity*dt, the drag products, two damped wall reflections per
// axis, and v*dt. When the output is stalled the whole pipe
// holds (in_ready follows out_ready through the output register). Config
// registers are written through cfg_we/cfg_index/cfg_data and must only be
// changed while no transaction is in flight; writes to indexes beyond the
// register list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_step_box_collide (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // config write port
  input  wire logic                                   cfg_we,
  input  wire logic        [psbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [psbc_pkg::CFG_DATA_W-1:0] cfg_data,
  // particle in
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]      pos_x,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]      pos_y,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]      vel_x,
  input  wire logic signed [psbc_pkg::VAL_W-1:0]      vel_y,
  input  wire logic        [psbc_pkg::AGE_W-1:0]      age,
  input  wire logic        [psbc_pkg::AGE_W-1:0]      lifetime,
  input  wire logic        [psbc_pkg::AGE_W-1:0]      step_time,
  // particle out
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed      [psbc_pkg::VAL_W-1:0]      new_pos_x,
  output logic signed      [psbc_pkg::VAL_W-1:0]      new_pos_y,
  output logic signed      [psbc_pkg::VAL_W-1:0]      new_vel_x,
  output logic signed      [psbc_pkg::VAL_W-1:0]      new_vel_y,
  output logic             [psbc_pkg::AGE_W-1:0]      new_age,
  output logic             [psbc_pkg::AGE_W-1:0]      kept_lifetime
);

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic signed [psbc_pkg::VAL_W-1:0]  gravity_accel;
  logic        [psbc_pkg::FACT_W-1:0] drag_factor;
  logic        [psbc_pkg::FACT_W-1:0] damping_factor;
  logic signed [psbc_pkg::VAL_W-1:0]  box_origin_x;
  logic signed [psbc_pkg::VAL_W-1:0]  box_origin_y;
  logic        [psbc_pkg::AGE_W-1:0]  box_length;
  logic        [psbc_pkg::AGE_W-1:0]  box_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_accel  <= '0;
      drag_factor    <= psbc_pkg::FACTOR_ONE;
      damping_factor <= psbc_pkg::FACTOR_ONE;
      box_origin_x   <= '0;
      box_origin_y   <= '0;
      box_length     <= '0;
      box_height     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psbc_pkg::REG_GRAVITY:  gravity_accel  <= cfg_data;
        psbc_pkg::REG_DRAG:     drag_factor    <= cfg_data[psbc_pkg::FACT_W-1:0];
        psbc_pkg::REG_DAMPING:  damping_factor <= cfg_data[psbc_pkg::FACT_W-1:0];
        psbc_pkg::REG_ORIGIN_X: box_origin_x   <= cfg_data;
        psbc_pkg::REG_ORIGIN_Y: box_origin_y   <= cfg_data;
        psbc_pkg::REG_LENGTH:   box_length     <= cfg_data[psbc_pkg::AGE_W-1:0];
        psbc_pkg::REG_HEIGHT:   box_height     <= cfg_data[psbc_pkg::AGE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: one advance for the whole pipe, held while the output
  // register is full and not being drained.
  // --------------------------------------------------------------------------
  logic       adv;
  logic [6:0] vld;  // vld[k] = stage k+1 holds a transaction

  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stages 1-3: clamp, age check, gravity, drag
  // --------------------------------------------------------------------------
  logic signed [psbc_pkg::PROD_W-1:0] drag_x, drag_y;
  psbc_pkg::ctl_t                     ctl3, ctl4, ctl5, ctl6;

  psbc_front u_front (
    .clk           (clk),
    .en            (adv),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .age           (age),
    .lifetime      (lifetime),
    .step_time     (step_time),
    .gravity_accel (gravity_accel),
    .drag_factor   (drag_factor),
    .box_origin_x  (box_origin_x),
    .box_origin_y  (box_origin_y),
    .box_length    (box_length),
    .box_height    (box_height),
    .prod_x        (drag_x),
    .prod_y        (drag_y),
    .ctl           (ctl3)
  );

  // --------------------------------------------------------------------------
  // Stage 4: resolve drag, form edge reflection product
  // Stage 5: apply edge reflection if hit, form zero-wall reflection product
  // --------------------------------------------------------------------------
  logic signed [psbc_pkg::VAL_W-1:0]  vx4, vy4, vx5, vy5;
  logic signed [psbc_pkg::PROD_W-1:0] rx4, ry4, rx5, ry5;

  psbc_bounce u_edge_x (
    .clk (clk), .en (adv), .take (1'b1),
    .prod_in (drag_x), .prev_in ('0), .damping (damping_factor),
    .val_out (vx4), .prod_out (rx4)
  );

  psbc_bounce u_edge_y (
    .clk (clk), .en (adv), .take (1'b1),
    .prod_in (drag_y), .prev_in ('0), .damping (damping_factor),
    .val_out (vy4), .prod_out (ry4)
  );

  psbc_bounce u_zero_x (
    .clk (clk), .en (adv), .take (ctl4.hit_edge_x),
    .prod_in (rx4), .prev_in (vx4), .damping (damping_factor),
    .val_out (vx5), .prod_out (rx5)
  );

  psbc_bounce u_zero_y (
    .clk (clk), .en (adv), .take (ctl4.hit_edge_y),
    .prod_in (ry4), .prev_in (vy4), .damping (damping_factor),
    .val_out (vy5), .prod_out (ry5)
  );

  // --------------------------------------------------------------------------
  // Stages 6-7: final velocity, v*dt, position update (stage 7 is the
  // output register)
  // --------------------------------------------------------------------------
  psbc_move u_move_x (
    .clk (clk), .en (adv), .take (ctl5.hit_zero_x),
    .prod_in (rx5), .prev_in (vx5),
    .pos_in ($signed(ctl5.pos_x)), .dt (ctl5.dt),
    .new_pos (new_pos_x), .new_vel (new_vel_x)
  );

  psbc_move u_move_y (
    .clk (clk), .en (adv), .take (ctl5.hit_zero_y),
    .prod_in (ry5), .prev_in (vy5),
    .pos_in ($signed(ctl5.pos_y)), .dt (ctl5.dt),
    .new_pos (new_pos_y), .new_vel (new_vel_y)
  );

  // side info travels alongside
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl4          <= ctl3;
      ctl5          <= ctl4;
      ctl6          <= ctl5;
      new_age       <= ctl6.new_age;
      kept_lifetime <= ctl6.life;
    end
  end

  // valid chain; dead particles drop out entering the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5] & ctl6.alive, vld[4:0], in_valid};
    end
  end

  assign out_valid = vld[6];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_holds_pipe: assert property (
    @(posedge clk) disable iff (rst) !adv |=> $stable(vld)
  ) else $error("pipeline valid bits moved during an output stall");

  a_out_from_live: assert property (
    @(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(vld[5] && ctl6.alive)
  ) else $error("output transaction without a live particle in stage 6");

endmodule

`default_nettype wire

/* dv/particle_step_box_collide_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_step_box_collide_test
// Self-checking bench for the one-frame particle update with box walls.
// ----------------------------------------------------------------------------
// Directed tests cover reset values, field extremes, each wall, dropping on
// lifetime, factor extremes and a write to an unused register index. Random
// phases follow under several register settings and pacing patterns. Every
// accepted input transaction is run through a local fixed-point predictor.
// Every output transaction is checked, field by field, against the oldest
// pending prediction.
// ----------------------------------------------------------------------------

module particle_step_box_collide_test;

  import psbc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind it
  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;
  localparam longint AGE_MAX    = 64'sd2147483647;
  localparam int     IDLE_PCT   = 69;
  localparam int     BOTH_PCT   = 17;
  localparam int     FLUSH_CYC  = 16;      // exceeds the 7-stage pipe depth
  localparam int     PHASES     = 8;
  localparam int     PHASE_LEN  = 125;
  localparam int     TIMEOUT_NS = 5_000_000;

  typedef enum int {PACE_FLOW, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic        [AGE_W-1:0] age;
    logic        [AGE_W-1:0] lifetime;
    logic        [AGE_W-1:0] step_time;
  } particle_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_pos_x;
    logic [VAL_W-1:0] new_pos_y;
    logic [VAL_W-1:0] new_vel_x;
    logic [VAL_W-1:0] new_vel_y;
    logic [AGE_W-1:0] new_age;
    logic [AGE_W-1:0] kept_lifetime;
  } update_t;

  // DUT connections; every input known from time zero
  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] pos_x     = '0;
  logic signed [VAL_W-1:0] pos_y     = '0;
  logic signed [VAL_W-1:0] vel_x     = '0;
  logic signed [VAL_W-1:0] vel_y     = '0;
  logic [AGE_W-1:0]        age       = '0;
  logic [AGE_W-1:0]        lifetime  = '0;
  logic [AGE_W-1:0]        step_time = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic signed [VAL_W-1:0] new_pos_x;
  logic signed [VAL_W-1:0] new_pos_y;
  logic signed [VAL_W-1:0] new_vel_x;
  logic signed [VAL_W-1:0] new_vel_y;
  logic [AGE_W-1:0]        new_age;
  logic [AGE_W-1:0]        kept_lifetime;

  // local copy of the register file, held wide for the arithmetic
  longint gravity_q  = 0;
  longint drag_q     = 65536;
  longint damping_q  = 65536;
  longint origin_x_q = 0;
  longint origin_y_q = 0;
  longint length_q   = 0;
  longint height_q   = 0;

  update_t pending_updates[$];  // predicted particles, oldest first
  update_t oldest_update;
  int      mismatch_count = 0;
  int      src_idle_pct   = 0;
  int      snk_stall_pct  = 0;

  particle_step_box_collide u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .age           (age),
    .lifetime      (lifetime),
    .step_time     (step_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_pos_x     (new_pos_x),
    .new_pos_y     (new_pos_y),
    .new_vel_x     (new_vel_x),
    .new_vel_y     (new_vel_y),
    .new_age       (new_age),
    .kept_lifetime (kept_lifetime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_q(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // product then floor shift; operands stay below 2^62 in magnitude
  function automatic longint mul_shift(input longint a, input longint b, input int n);
    return (a * b) >>> n;
  endfunction

  function automatic longint apply_factor(input longint v, input longint f);
    return sat_q(mul_shift(v, f, FACTOR_BITS));
  endfunction

  // Returns 0 when the particle dies; u is then left alone.
  function automatic bit advance_particle(input particle_t p, output update_t u);
    longint px, py, vx, vy, age_q, life_q, dt_q, edge_x, edge_y, na;
    px     = p.pos_x;
    py     = p.pos_y;
    vx     = p.vel_x;
    vy     = p.vel_y;
    age_q  = p.age;
    life_q = p.lifetime;
    dt_q   = p.step_time;
    edge_x = sat_q(origin_x_q + length_q);
    edge_y = sat_q(origin_y_q + height_q);

    vy = sat_q(vy + mul_shift(gravity_q, dt_q, FRAC_BITS));
    vx = apply_factor(vx, drag_q);
    vy = apply_factor(vy, drag_q);

    // far wall first, then zero on the already clamped value
    if (px > edge_x) begin
      vx = apply_factor(-vx, damping_q);
      px = edge_x;
    end
    if (px < 0) begin
      vx = apply_factor(-vx, damping_q);
      px = 0;
    end
    if (py > edge_y) begin
      vy = apply_factor(-vy, damping_q);
      py = edge_y;
    end
    if (py < 0) begin
      vy = apply_factor(-vy, damping_q);
      py = 0;
    end

    if (age_q >= life_q) begin
      return 1'b0;
    end

    px = sat_q(px + mul_shift(vx, dt_q, FRAC_BITS));
    py = sat_q(py + mul_shift(vy, dt_q, FRAC_BITS));
    na = age_q + dt_q;
    if (na > AGE_MAX) begin
      na = AGE_MAX;
    end

    u.new_pos_x     = px[VAL_W-1:0];
    u.new_pos_y     = py[VAL_W-1:0];
    u.new_vel_x     = vx[VAL_W-1:0];
    u.new_vel_y     = vy[VAL_W-1:0];
    u.new_age       = na[AGE_W-1:0];
    u.kept_lifetime = p.lifetime;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                             input logic [VAL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // sampled at the rising edge; the bench drives only on falling edges
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: output transaction with nothing pending, expected none actual %h",
                 $time, {new_pos_x, new_pos_y});
        mismatch_count++;
      end else begin
        oldest_update = pending_updates.pop_front();
        check_field("new_pos_x", oldest_update.new_pos_x, new_pos_x);
        check_field("new_pos_y", oldest_update.new_pos_y, new_pos_y);
        check_field("new_vel_x", oldest_update.new_vel_x, new_vel_x);
        check_field("new_vel_y", oldest_update.new_vel_y, new_vel_y);
        check_field("new_age", {1'b0, oldest_update.new_age}, {1'b0, new_age});
        check_field("kept_lifetime", {1'b0, oldest_update.kept_lifetime},
                    {1'b0, kept_lifetime});
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic set_pacing(input pace_t pace);
    case (pace)
      PACE_FLOW: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        src_idle_pct  = IDLE_PCT;
        snk_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        src_idle_pct  = 0;
        snk_stall_pct = IDLE_PCT;
      end
      default: begin
        src_idle_pct  = BOTH_PCT;
        snk_stall_pct = BOTH_PCT;
      end
    endcase
  endtask

  // Returns at the rising edge that accepted the transaction; valid stays up
  // so back-to-back sends do not drop it between transactions.
  task automatic send_particle(input particle_t p);
    update_t u;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    pos_x     <= p.pos_x;
    pos_y     <= p.pos_y;
    vel_x     <= p.vel_x;
    vel_y     <= p.vel_y;
    age       <= p.age;
    lifetime  <= p.lifetime;
    step_time <= p.step_time;
    do @(posedge clk); while (!in_ready);
    if (advance_particle(p, u)) begin
      pending_updates.push_back(u);
    end
  endtask

  // Wait until nothing is pending, then let a dropped particle leave the
  // pipe: it produces no transaction, so count cycles with the output open.
  task automatic drain_pipe();
    int open_cycles;
    open_cycles = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) begin
      @(posedge clk);
    end
    while (open_cycles < FLUSH_CYC) begin
      @(posedge clk);
      if (out_ready) begin
        open_cycles++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_GRAVITY:  gravity_q  = $signed(d);
      REG_DRAG:     drag_q     = d[FACT_W-1:0];
      REG_DAMPING:  damping_q  = d[FACT_W-1:0];
      REG_ORIGIN_X: origin_x_q = $signed(d);
      REG_ORIGIN_Y: origin_y_q = $signed(d);
      REG_LENGTH:   length_q   = d[AGE_W-1:0];
      REG_HEIGHT:   height_q   = d[AGE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // full register set, only once the pipe is empty
  task automatic set_box(input logic [31:0] grav, input logic [31:0] drag,
                         input logic [31:0] damp, input logic [31:0] ox,
                         input logic [31:0] oy, input logic [31:0] len,
                         input logic [31:0] ht);
    drain_pipe();
    write_reg(REG_GRAVITY, grav);
    write_reg(REG_DRAG, drag);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_LENGTH, len);
    write_reg(REG_HEIGHT, ht);
  endtask

  function automatic particle_t make_particle(
    input logic [31:0] px, input logic [31:0] py, input logic [31:0] vx,
    input logic [31:0] vy, input logic [30:0] a, input logic [30:0] l,
    input logic [30:0] dt
  );
    particle_t p;
    p.pos_x     = px;
    p.pos_y     = py;
    p.vel_x     = vx;
    p.vel_y     = vy;
    p.age       = a;
    p.lifetime  = l;
    p.step_time = dt;
    return p;
  endfunction

  // coordinate spread around [0, limit] with some margin on both sides
  function automatic logic [31:0] rand_coord(input longint limit);
    longint span;
    span = limit;
    if (span < 64'sh10000) begin
      span = 64'sh100000;
    end else if (span > 64'sh40000000) begin
      span = 64'sh40000000;
    end
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return 32'(longint'($urandom_range(0, 32'(span + span / 4))) - span / 8);
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    int unsigned kind;
    kind        = $urandom_range(99);
    p.pos_x     = rand_coord(sat_q(origin_x_q + length_q));
    p.pos_y     = rand_coord(sat_q(origin_y_q + height_q));
    p.vel_x     = $signed($urandom) >>> $urandom_range(4, 20);
    p.vel_y     = $signed($urandom) >>> $urandom_range(4, 20);
    p.step_time = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h20000));
    p.lifetime  = 31'($urandom_range(1, 32'h7FFFFFFF));
    if (kind < 70) begin
      // live particle
      p.age = 31'($urandom_range(0, 32'(p.lifetime) - 1));
    end else if (kind < 85) begin
      // expired particle
      p.age = 31'($urandom_range(32'(p.lifetime), 32'h7FFFFFFF));
    end else begin
      // raw bits everywhere
      p = {$urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
           31'($urandom)};
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // registers at reset values: edges at zero, unit factors, no gravity
  task automatic test_reset_defaults();
    send_particle(make_particle(32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 31'h1, 31'h0));
    send_particle(make_particle(32'h10000, 32'h20000, 32'h18000, -32'sh4000,
                                31'h0, 31'h100000, 31'h10000));
    send_particle(make_particle(-32'sh10000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                31'h5, 31'h6, 31'h7FFFFFFF));
  endtask

  task automatic test_field_extremes();
    set_box(-32'sh9CCCC, 32'hFD70, 32'hCCCC, 32'h0, 32'h0, 32'h1000000, 32'h800000);
    // age plus dt saturates
    send_particle(make_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                31'h7FFFFFFE, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_particle(make_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                31'h0, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_particle(make_particle(32'h12345678, 32'h00ABCDEF, 32'hFFFF0000, 32'h00010000,
                                31'h0, 31'h1, 31'h0));
    send_particle(make_particle(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                                31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA));
  endtask

  task automatic test_walls();
    // edge_x = 0x110000, edge_y = 0xA0000
    set_box(-32'sh9CCCC, 32'hFD70, 32'hCCCC, 32'h10000, 32'h20000, 32'h100000, 32'h80000);
    send_particle(make_particle(32'h40000, 32'h30000, 32'h8000, -32'sh10000,
                                31'h0, 31'h100000, 31'h4000));
    send_particle(make_particle(32'h200000, 32'h30000, 32'h20000, 32'h1000,
                                31'h1000, 31'h20000, 31'h8000));
    send_particle(make_particle(32'h30000, 32'h7FFFFFFF, -32'sh1000, 32'h50000,
                                31'h0, 31'h1, 31'h10000));
    send_particle(make_particle(-32'sh8000, 32'h80000000, -32'sh30000, 32'h80000000,
                                31'h0, 31'h10000, 31'h1000));
    // on the edge exactly: not past it
    send_particle(make_particle(32'h110000, 32'hA0000, 32'h10000, 32'h10000,
                                31'h0, 31'h10000, 31'h10000));
    // edge below zero: far wall and zero wall both hit
    set_box(32'h0, 32'h10000, 32'hC000, -32'sh100000, -32'sh10000, 32'h10, 32'h0);
    send_particle(make_particle(32'h5000, 32'h0, 32'h30000, -32'sh20000,
                                31'h0, 31'h10000, 31'h10000));
    // origin plus extent saturates
    set_box(32'h0, 32'h10000, 32'h10000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF);
    send_particle(make_particle(32'h7FFFFFFF, 32'h7FFFFFF0, 32'h7FFFFFFF, 32'h10000,
                                31'h0, 31'h7FFFFFFF, 31'h7FFFFFFF));
  endtask

  task automatic test_lifetime();
    set_box(32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h100000, 32'h100000);
    send_particle(make_particle(32'h1000, 32'h1000, 32'h100, 32'h100,
                                31'h20000, 31'h20000, 31'h100));
    send_particle(make_particle(32'h1000, 32'h1000, 32'h100, 32'h100,
                                31'h7FFFFFFF, 31'h1, 31'h100));
    send_particle(make_particle(32'h1000, 32'h1000, 32'h100, 32'h100,
                                31'h0, 31'h0, 31'h100));
    send_particle(make_particle(32'h1000, 32'h1000, 32'h100, 32'h100,
                                31'h1FFFF, 31'h20000, 31'h100));
  endtask

  task automatic test_factors();
    set_box(32'h7FFFFFFF, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h1000000, 32'h1000000);
    send_particle(make_particle(32'h100, 32'h100, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                31'h0, 31'h1, 31'h7FFFFFFF));
    // factors above one, strongest gravity down
    set_box(32'h80000000, 32'h1FFFF, 32'h1FFFF, 32'h0, 32'h0, 32'h100000, 32'h100000);
    send_particle(make_particle(32'hFFFFFFFF, 32'h200000, 32'h40000000, 32'h80000000,
                                31'h0, 31'h2, 31'h7FFFFFFF));
    send_particle(make_particle(32'h1000, 32'h1000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                                31'h0, 31'h2, 31'h100));
    // zero damping kills the reflected component
    set_box(32'h12340, 32'h8000, 32'h0, 32'h0, 32'h0, 32'h100000, 32'h100000);
    send_particle(make_particle(32'h7FFFFFFF, -32'sh5, 32'h10000, 32'h10000,
                                31'h0, 31'h1, 31'h10000));
  endtask

  // index past the register list must change nothing
  task automatic test_register_index();
    drain_pipe();
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    send_particle(make_particle(32'h200000, -32'sh100, 32'h30000, -32'sh30000,
                                31'h0, 31'h40000, 31'h10000));
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_box(-32'sh9CCCC, 32'hFD70, 32'hCCCC, 32'h0, 32'h0, 32'h1000000, 32'h800000);
        1: set_box(32'h7FFFFFFF, 32'h10000, 32'h10000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF);
        2: set_box(32'h80000000, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        3: set_box(-32'sh4000, 32'hF000, 32'h8000, 32'h80000, 32'h40000, 32'h400000,
                   32'h200000);
        default: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
      endcase
      set_pacing(pace_t'(phase % 4));
      repeat (PHASE_LEN) begin
        send_particle(rand_particle());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    set_pacing(PACE_FLOW);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_walls();
    test_lifetime();
    test_factors();
    test_register_index();
    test_random_stream();

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("particle_step_box_collide test passed");
    end else begin
      $display("particle_step_box_collide test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("particle_step_box_collide test failed");
    $finish;
  end

endmodule
